/* hw/rtl/bomsc_pkg.sv */
// Shared constants for the box overlap match score core.
// No dependencies; imported by every module of the block.
package bomsc_pkg;

    localparam int COORD_BITS_DEF      = 12;
    localparam int SCORE_FRAC_BITS_DEF = 16;
    localparam int DIST_FRAC_BITS      = 8;
    localparam int SCORE_BITS          = 23;
    localparam int SCALE               = 100;
    localparam int SCALE_BITS          = 7;

endpackage

/* hw/rtl/bomsc_sqrt_pipe.sv */
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word alongside; uses bomsc_pkg.
module bomsc_sqrt_pipe #(
    parameter int RW     = 43,
    parameter int SIDE_W = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_vld,
    input  logic [RW-1:0]                   radicand,
    input  logic [SIDE_W-1:0]               side_in,
    output logic                            out_vld,
    output logic [(RW + (RW % 2)) / 2 - 1:0] root,
    output logic [SIDE_W-1:0]               side_out
);
    import bomsc_pkg::*;

    localparam int RWE = RW + (RW % 2);
    localparam int SB  = RWE / 2;
    localparam int RMW = SB + 2;

    logic [RWE-1:0]    p_rad  [SB+1];
    logic [SB-1:0]     p_root [SB+1];
    logic [RMW-1:0]    p_rem  [SB+1];
    logic              p_vld  [SB+1];
    logic [SIDE_W-1:0] p_side [SB+1];

    assign p_rad[0]  = RWE'(radicand);
    assign p_root[0] = '0;
    assign p_rem[0]  = '0;
    assign p_vld[0]  = in_vld;
    assign p_side[0] = side_in;

    genvar i;
    generate
        for (i = 0; i < SB; i++) begin : g_stage
            logic [RWE-1:0]    rad_reg;
            logic [SB-1:0]     root_reg;
            logic [RMW-1:0]    rem_reg;
            logic              vld_reg;
            logic [SIDE_W-1:0] side_reg;
            logic [RMW-1:0]    rem_sh;
            logic [RMW-1:0]    trial;
            logic [RMW-1:0]    rem_next;
            logic [SB-1:0]     root_next;

            always_comb
            begin
                rem_sh = {p_rem[i][RMW-3:0], p_rad[i][RWE-1:RWE-2]};
                trial  = {p_root[i], 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {p_root[i][SB-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {p_root[i][SB-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg <= 1'b0;
                else if (adv)
                    vld_reg <= p_vld[i];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rad_reg  <= {p_rad[i][RWE-3:0], 2'b00};
                    root_reg <= root_next;
                    rem_reg  <= rem_next;
                    side_reg <= p_side[i];
                end
            end

            assign p_rad[i+1]  = rad_reg;
            assign p_root[i+1] = root_reg;
            assign p_rem[i+1]  = rem_reg;
            assign p_vld[i+1]  = vld_reg;
            assign p_side[i+1] = side_reg;
        end
    endgenerate

    assign out_vld  = p_vld[SB];
    assign root     = p_root[SB];
    assign side_out = p_side[SB];

endmodule

/* hw/rtl/bomsc_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Quotient must fit in QW bits; uses bomsc_pkg.
module bomsc_div_pipe #(
    parameter int NW     = 55,
    parameter int DW     = 47,
    parameter int QW     = 23,
    parameter int SIDE_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_vld,
    input  logic [NW-1:0]     num,
    input  logic [DW-1:0]     den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [QW-1:0]     quot,
    output logic [SIDE_W-1:0] side_out
);
    import bomsc_pkg::*;

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0]     p_rem  [QW+1];
    logic [DW-1:0]     p_den  [QW+1];
    logic [QW-1:0]     p_q    [QW+1];
    logic              p_vld  [QW+1];
    logic [SIDE_W-1:0] p_side [QW+1];

    assign p_rem[0]  = CW'(num);
    assign p_den[0]  = den;
    assign p_q[0]    = '0;
    assign p_vld[0]  = in_vld;
    assign p_side[0] = side_in;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [CW-1:0]     rem_reg;
            logic [DW-1:0]     den_reg;
            logic [QW-1:0]     q_reg;
            logic              vld_reg;
            logic [SIDE_W-1:0] side_reg;
            logic [CW-1:0]     dsh;
            logic              take;

            always_comb
            begin
                dsh  = CW'(p_den[k]) << (QW - 1 - k);
                take = (p_rem[k] >= dsh);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg <= 1'b0;
                else if (adv)
                    vld_reg <= p_vld[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg  <= take ? p_rem[k] - dsh : p_rem[k];
                    den_reg  <= p_den[k];
                    q_reg    <= {p_q[k][QW-2:0], take};
                    side_reg <= p_side[k];
                end
            end

            assign p_rem[k+1]  = rem_reg;
            assign p_den[k+1]  = den_reg;
            assign p_q[k+1]    = q_reg;
            assign p_vld[k+1]  = vld_reg;
            assign p_side[k+1] = side_reg;
        end
    endgenerate

    assign out_vld  = p_vld[QW];
    assign quot     = p_q[QW];
    assign side_out = p_side[QW];

endmodule

/* hw/rtl/box_overlap_match_score_core.sv */
// Box overlap match score: IoU scaled by 100 over center distance, Q.16.
// Pipeline: stages A, B and C, square root, stage D, divider, output stage.
// Throughput: one beat per cycle unless stalled; sqrt and divider do one bit per stage.
// A stalled output freezes the whole pipeline; in_stall follows it.
// Reset clears all valid bits asynchronously; data registers are not reset.
module box_overlap_match_score_core #(
    parameter int COORD_BITS      = bomsc_pkg::COORD_BITS_DEF,
    parameter int SCORE_FRAC_BITS = bomsc_pkg::SCORE_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [COORD_BITS-1:0]         first_left,
    input  logic [COORD_BITS-1:0]         first_top,
    input  logic [COORD_BITS-1:0]         first_width,
    input  logic [COORD_BITS-1:0]         first_height,
    input  logic [COORD_BITS-1:0]         second_left,
    input  logic [COORD_BITS-1:0]         second_top,
    input  logic [COORD_BITS-1:0]         second_width,
    input  logic [COORD_BITS-1:0]         second_height,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bomsc_pkg::SCORE_BITS-1:0] match_score,
    output logic                          centers_coincide,
    output logic                          union_empty
);
    import bomsc_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int F    = SCORE_FRAC_BITS;
    localparam int AW   = 2 * C;
    localparam int UW   = 2 * C + 1;
    localparam int EW   = C + 1;
    localparam int SSW  = 2 * C + 3;
    localparam int RW   = SSW + 2 * DIST_FRAC_BITS;
    localparam int SB   = (RW + (RW % 2)) / 2;
    localparam int NMW  = AW + SCALE_BITS;
    localparam int NW   = NMW + F + DIST_FRAC_BITS;
    localparam int DW   = UW + SB;
    localparam int QW   = F + SCALE_BITS;
    localparam int LW   = (QW > SCORE_BITS) ? QW : SCORE_BITS;
    localparam int SW1  = UW + NMW + 1;
    localparam logic [QW-1:0] SMAX      = QW'(SCALE) << F;
    localparam logic [LW-1:0] FIELD_MAX = LW'((64'd1 << SCORE_BITS) - 64'd1);

    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage A: areas, intersection extents, center offsets
    logic [EW-1:0] r1, r2, b1, b2, ix0, iy0, ix1, iy1;
    logic [EW-1:0] cx1, cy1, cx2, cy2;
    logic          a_vld_reg;
    logic [AW-1:0] a1_reg, a2_reg;
    logic [EW-1:0] iw_reg, ih_reg, dx_reg, dy_reg;

    always_comb
    begin
        r1  = EW'(first_left) + EW'(first_width);
        r2  = EW'(second_left) + EW'(second_width);
        b1  = EW'(first_top) + EW'(first_height);
        b2  = EW'(second_top) + EW'(second_height);
        ix0 = EW'((first_left > second_left) ? first_left : second_left);
        iy0 = EW'((first_top > second_top) ? first_top : second_top);
        ix1 = (r1 < r2) ? r1 : r2;
        iy1 = (b1 < b2) ? b1 : b2;
        cx1 = EW'(first_left) + EW'(first_width >> 1);
        cy1 = EW'(first_top) + EW'(first_height >> 1);
        cx2 = EW'(second_left) + EW'(second_width >> 1);
        cy2 = EW'(second_top) + EW'(second_height >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= AW'(first_width) * AW'(first_height);
            a2_reg <= AW'(second_width) * AW'(second_height);
            if (ix1 > ix0 && iy1 > iy0)
            begin
                iw_reg <= ix1 - ix0;
                ih_reg <= iy1 - iy0;
            end
            else
            begin
                iw_reg <= '0;
                ih_reg <= '0;
            end
            dx_reg <= (cx1 > cx2) ? cx1 - cx2 : cx2 - cx1;
            dy_reg <= (cy1 > cy2) ? cy1 - cy2 : cy2 - cy1;
        end
    end

    // stage B: intersection area, squared distance
    logic           b_vld_reg;
    logic [AW-1:0]  b_a1_reg, b_a2_reg, a0_reg;
    logic [SSW-1:0] sumsq_reg;
    logic [2*EW-1:0] a0_full;

    assign a0_full = (2 * EW)'(iw_reg) * (2 * EW)'(ih_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (adv)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_a1_reg  <= a1_reg;
            b_a2_reg  <= a2_reg;
            a0_reg    <= a0_full[AW-1:0];
            sumsq_reg <= SSW'(dx_reg * dx_reg) + SSW'(dy_reg * dy_reg);
        end
    end

    // stage C: union, scaled numerator
    logic           c_vld_reg;
    logic [UW-1:0]  uni_reg;
    logic [NMW-1:0] num_reg;
    logic           empty_reg;
    logic [SSW-1:0] c_sumsq_reg;
    logic [UW-1:0]  uni_next;

    assign uni_next = UW'(b_a1_reg) + UW'(b_a2_reg) - UW'(a0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (adv)
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uni_reg     <= uni_next;
            num_reg     <= NMW'(a0_reg) * NMW'(SCALE);
            empty_reg   <= (uni_next == '0);
            c_sumsq_reg <= sumsq_reg;
        end
    end

    // square root of the squared distance, giving the distance in Q.8
    logic           s_vld;
    logic [SB-1:0]  dist_q8;
    logic [SW1-1:0] s_side;

    bomsc_sqrt_pipe #(
        .RW     (RW),
        .SIDE_W (SW1)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (c_vld_reg),
        .radicand ({c_sumsq_reg, {(2 * DIST_FRAC_BITS){1'b0}}}),
        .side_in  ({uni_reg, num_reg, empty_reg}),
        .out_vld  (s_vld),
        .root     (dist_q8),
        .side_out (s_side)
    );

    // stage D: divisor = union * distance
    logic           d_vld_reg;
    logic [DW-1:0]  den_reg;
    logic [NW-1:0]  dnum_reg;
    logic           d_empty_reg, d_coin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (adv)
            d_vld_reg <= s_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg     <= DW'(s_side[SW1-1 -: UW]) * DW'(dist_q8);
            dnum_reg    <= {s_side[NMW:1], {(F + DIST_FRAC_BITS){1'b0}}};
            d_empty_reg <= s_side[0];
            d_coin_reg  <= (dist_q8 == '0);
        end
    end

    logic          q_vld;
    logic [QW-1:0] quot;
    logic [1:0]    q_side;

    bomsc_div_pipe #(
        .NW     (NW),
        .DW     (DW),
        .QW     (QW),
        .SIDE_W (2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (d_vld_reg),
        .num      (dnum_reg),
        .den      (den_reg),
        .side_in  ({d_coin_reg, d_empty_reg}),
        .out_vld  (q_vld),
        .quot     (quot),
        .side_out (q_side)
    );

    // output stage: flags and saturation
    logic [QW-1:0] cand;
    logic [LW-1:0] cand_w;
    logic          out_valid_reg;
    logic [SCORE_BITS-1:0] score_reg;
    logic          coin_reg, empty_out_reg;

    always_comb
    begin
        if (q_side[0])
            cand = '0;
        else if (q_side[1])
            cand = SMAX;
        else if (quot > SMAX)
            cand = SMAX;
        else
            cand = quot;
        cand_w = LW'(cand);
        if (cand_w > FIELD_MAX)
            cand_w = FIELD_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= q_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            score_reg     <= cand_w[SCORE_BITS-1:0];
            coin_reg      <= q_side[1] && !q_side[0];
            empty_out_reg <= q_side[0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign match_score      = score_reg;
    assign centers_coincide = coin_reg;
    assign union_empty      = empty_out_reg;

endmodule

/* hw/rtl/bomsc_checker.sv */
// Port-level checks for box_overlap_match_score_core, bound to the top level.
// Uses bomsc_pkg.
module bomsc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [bomsc_pkg::SCORE_BITS-1:0] match_score,
    input logic                             centers_coincide,
    input logic                             union_empty
);
    import bomsc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(match_score)
            && $stable(centers_coincide) && $stable(union_empty))
        else $error("stalled result changed");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_empty_score: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && union_empty |-> match_score == '0 && !centers_coincide)
        else $error("empty union with nonzero score or coincide flag");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> out_valid)
        else $error("result dropped while input was stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled input beat withdrawn");

endmodule

bind box_overlap_match_score_core bomsc_checker u_bomsc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .match_score      (match_score),
    .centers_coincide (centers_coincide),
    .union_empty      (union_empty)
);
